### hdl/w256_pkg.sv
// Package for the 256-bit arithmetic unit: operation codes, state encoding, constants.
`default_nettype none
package w256_pkg;
    localparam int unsigned DefWordBytes = 32;
    localparam int unsigned PortBits     = 256;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_UDIV = 3'd3,
        FN_SDIV = 3'd4,
        FN_UMOD = 3'd5,
        FN_SMOD = 3'd6,
        FN_EXP  = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIX,
        ST_MUL,
        ST_ESQ,
        ST_EMUL,
        ST_ENEXT,
        ST_OUT
    } t_state;

    // Control from the sequencer to the shared multiplier
    typedef struct packed {
        logic start;
    } t_mul_ctl;
endpackage
`default_nettype wire

### hdl/w256_mul.sv
// Shift-and-add multiplier, modulo 2^W, four multiplier bits per cycle.
`default_nettype none
module w256_mul
    import w256_pkg::*;
#(
    parameter int unsigned W = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_mul_ctl     i_ctl,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    output logic              o_done,
    output logic [W-1:0]      o_p
);
    localparam int unsigned Steps = (W + 3) / 4;
    localparam int unsigned CW    = $clog2(Steps + 1);

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_mc, n_mc;
    logic [W-1:0]  r_ml, n_ml;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    // One radix-16 step: add up to four shifted multiplicands
    always_comb begin
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_ml   = r_ml;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_acc  = '0;
            n_mc   = i_x;
            n_ml   = i_y;
            n_cnt  = CW'(Steps);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_acc + (r_ml[0] ? r_mc : '0) + (r_ml[1] ? (r_mc << 1) : '0)
                  + (r_ml[2] ? (r_mc << 2) : '0) + (r_ml[3] ? (r_mc << 3) : '0);
            n_mc  = r_mc << 4;
            n_ml  = r_ml >> 4;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_ml  <= n_ml;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule
`default_nettype wire

### hdl/word256_arith_unit_top.sv
// Top level of the 256-bit arithmetic unit: handshake, sequencer, divider, exponent loop.
//
// Usage: an item enters on the s_axis group (func, operands a and b) and one
// result item leaves on the m_axis group (result and divide-by-zero flag).
// The block holds one item at a time; s_axis_tready is high only while idle.
// Sequencing after acceptance, per function:
//   add, sub       : computed in the prepare state
//   mul            : through the shared radix-16 multiplier
//   div, mod       : one restoring step per bit; straight to the output
//                    when the divisor is zero
//   exp            : a square through the shared multiplier per exponent
//                    bit, and a multiply as well when that bit is set
// W is 8 * WORD_BYTES. Reset clears the sequencer and the output valid.
// A result waits in the output register while the receiver stalls; no new
// item is taken until it has been delivered.
`default_nettype none
module word256_arith_unit_top
    import w256_pkg::*;
#(
    parameter int unsigned WORD_BYTES = DefWordBytes
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: func[2:0], a_limb0..a_limb3, b_limb0..b_limb3, then zero fill
    input  wire logic [519:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: result_limb0..result_limb3, divide_by_zero, then zero fill
    output logic [263:0]      m_axis_tdata
);
    localparam int unsigned W  = 8 * WORD_BYTES;
    localparam int unsigned BW = $clog2(W + 1);

    t_state         r_st, n_st;
    t_func          r_fn;
    logic [W-1:0]   r_a, r_b, r_r, r_q;
    logic [W:0]     r_rem;
    logic [BW-1:0]  r_cnt;
    logic           r_sa, r_sb, r_dz;
    logic [PortBits-1:0] r_res;
    logic           r_vld;
    t_mul_ctl       w_mctl;
    logic [W-1:0]   w_mx, w_my, w_mp;
    logic           w_mdone;
    logic [W-1:0]   w_in_a, w_in_b;
    logic [W:0]     w_shift, w_diff;
    logic [W-1:0]   w_fin;
    logic           w_signed;
    logic           w_dz;

    // Operand extraction, truncated or zero extended to the word
    always_comb begin
        logic [W+PortBits-1:0] ta, tb;
        ta = {{W{1'b0}}, s_axis_tdata[258:3]};
        tb = {{W{1'b0}}, s_axis_tdata[514:259]};
        w_in_a = ta[W-1:0];
        w_in_b = tb[W-1:0];
    end

    assign w_signed = (r_fn == FN_SDIV) || (r_fn == FN_SMOD);
    assign w_dz     = (r_fn != FN_ADD) && (r_fn != FN_SUB) && (r_fn != FN_MUL)
                   && (r_fn != FN_EXP) && (r_b == '0);
    assign w_shift  = {r_rem[W-1:0], r_a[W-1]};
    assign w_diff   = w_shift - {1'b0, r_b};

    // Sign fix of the division result
    always_comb begin
        unique case (r_fn)
            FN_SDIV: w_fin = (r_sa != r_sb) ? -r_q : r_q;
            FN_UMOD: w_fin = r_rem[W-1:0];
            FN_SMOD: w_fin = r_sa ? -r_rem[W-1:0] : r_rem[W-1:0];
            default: w_fin = r_q;
        endcase
    end

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (s_axis_tvalid && !r_vld) n_st = ST_PREP;
            ST_PREP: begin
                unique case (r_fn)
                    FN_ADD, FN_SUB: n_st = ST_OUT;
                    FN_MUL:         n_st = ST_MUL;
                    FN_EXP:         n_st = ST_ESQ;
                    default:        n_st = (r_b == '0) ? ST_OUT : ST_DIV;
                endcase
            end
            ST_DIV:   if (r_cnt == BW'(1)) n_st = ST_FIX;
            ST_FIX:   n_st = ST_OUT;
            ST_MUL:   if (w_mdone) n_st = ST_OUT;
            ST_ESQ:   if (w_mdone) n_st = r_b[W-1] ? ST_EMUL : ST_ENEXT;
            ST_EMUL:  if (w_mdone) n_st = ST_ENEXT;
            ST_ENEXT: n_st = (r_cnt == BW'(1)) ? ST_OUT : ST_ESQ;
            ST_OUT:   n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // Multiplier control: start on entry to a multiply state
    always_comb begin
        w_mctl.start = 1'b0;
        w_mx = r_r;
        w_my = r_r;
        unique case (r_st)
            ST_PREP: begin
                // first square of the exponent loop is 1 * 1
                w_mctl.start = (r_fn == FN_MUL) || (r_fn == FN_EXP);
                w_mx = (r_fn == FN_MUL) ? r_a : {{(W-1){1'b0}}, 1'b1};
                w_my = (r_fn == FN_MUL) ? r_b : {{(W-1){1'b0}}, 1'b1};
            end
            ST_ESQ: if (w_mdone && r_b[W-1]) begin
                w_mctl.start = 1'b1;
                w_mx = w_mp;
                w_my = r_a;
            end
            ST_ENEXT: if (r_cnt != BW'(1)) begin
                w_mctl.start = 1'b1;
                w_mx = r_r;
                w_my = r_r;
            end
            default: w_mctl.start = 1'b0;
        endcase
    end

    w256_mul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_x     (w_mx),
        .i_y     (w_my),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: if (s_axis_tvalid && !r_vld) begin
                r_fn <= t_func'(s_axis_tdata[2:0]);
                r_a  <= w_in_a;
                r_b  <= w_in_b;
            end
            ST_PREP: begin
                r_sa  <= w_signed & r_a[W-1];
                r_sb  <= w_signed & r_b[W-1];
                r_dz  <= w_dz;
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= BW'(W);
                if (r_fn == FN_EXP)      r_r <= {{(W-1){1'b0}}, 1'b1};
                else if (w_dz)           r_r <= '0;
                else if (r_fn == FN_SUB) r_r <= r_a - r_b;
                else                     r_r <= r_a + r_b;
                if (w_signed && r_a[W-1]) r_a <= -r_a;
                if (w_signed && r_b[W-1]) r_b <= -r_b;
            end
            ST_DIV: begin
                if (w_shift[W] || !w_diff[W]) begin
                    r_rem <= w_diff;
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_a   <= r_a << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            ST_FIX: r_r <= w_fin;
            ST_MUL: if (w_mdone) r_r <= w_mp;
            ST_ESQ: if (w_mdone) r_r <= w_mp;
            ST_EMUL: if (w_mdone) r_r <= w_mp;
            ST_ENEXT: begin
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
        if (r_st == ST_OUT) r_res <= PortBits'({{PortBits{1'b0}}, r_r});
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_OUT) r_vld <= 1'b1;
            else if (m_axis_tready) r_vld <= 1'b0;
        end
    end

    logic r_dzo;
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT) r_dzo <= r_dz;
    end

    assign s_axis_tready = (r_st == ST_IDLE) && !r_vld;
    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {7'd0, r_dzo, r_res};
endmodule
`default_nettype wire
